[sv/kdlpmc_pkg.sv]
// Shared types, constants and register codes for the key debounce / click detector.
`timescale 1ns / 1ps
package kdlpmc_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int LEVEL_W      = 4;
  localparam int MAX_RESULTS  = 4;
  localparam int QUEUE_DEPTH  = 16;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam int PADDR_W      = 4;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd10;
  localparam logic [15:0] LONG_RST     = 16'd1000;
  localparam logic [15:0] WINDOW_RST   = 16'd300;
  localparam logic [15:0] DUR_MAX      = 16'hFFFF;
  localparam logic [3:0]  CLICK_MAX    = 4'd15;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  localparam logic EVT_LONG  = 1'b0;
  localparam logic EVT_CLICK = 1'b1;

  typedef struct packed {
    logic        dbusy;
    logic [7:0]  dcnt;
    logic        pressed;
    logic [15:0] dur;
    logic        wbusy;
    logic [15:0] wcnt;
    logic [3:0]  clicks;
  } key_state_t;

  localparam int KEY_STATE_W = $bits(key_state_t);

  localparam key_state_t KEY_STATE_RST = '{
    dbusy: 1'b0, dcnt: 8'd0, pressed: 1'b0, dur: 16'd0,
    wbusy: 1'b0, wcnt: 16'd0, clicks: 4'd1
  };

  typedef struct packed {
    logic [7:0]  debounce;
    logic [15:0] long_press;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic [1:0] key;
    logic       kind;
    logic [3:0] count;
    logic       last;
  } evt_t;

  typedef struct packed {
    key_state_t st;
    logic       emit;
    logic       kind;
    logic [3:0] count;
  } key_upd_t;

endpackage

[sv/kdlpmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kdlpmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/kdlpmc_key_logic.sv]
// Per-key update: press timing, debounce and click window for one key in one tick.
`timescale 1ns / 1ps
module kdlpmc_key_logic import kdlpmc_pkg::*; (
  input  key_state_t st_i,
  input  logic       lvl_i,
  input  logic       prev_i,
  input  cfg_t       cfg_i,
  output key_upd_t   upd_o
);

  key_state_t s;
  logic       emit;
  logic       kind;
  logic [3:0] count;

  always_comb begin
    s     = st_i;
    emit  = 1'b0;
    kind  = EVT_LONG;
    count = 4'd0;

    if (s.pressed && s.dur < DUR_MAX) begin
      s.dur = s.dur + 16'd1;
    end

    if (s.dbusy) begin
      if (s.dcnt <= 8'd1) begin
        s.dbusy = 1'b0;
        s.dcnt  = 8'd0;
        if (!lvl_i) begin
          s.pressed = 1'b1;
          s.dur     = 16'd0;
        end
      end else begin
        s.dcnt = s.dcnt - 8'd1;
      end
    end

    if (s.wbusy) begin
      if (s.wcnt <= 16'd1) begin
        s.wbusy = 1'b0;
        s.wcnt  = 16'd0;
        if (s.pressed) begin
          if (s.clicks < CLICK_MAX) begin
            s.clicks = s.clicks + 4'd1;
          end
        end else begin
          emit     = 1'b1;
          kind     = EVT_CLICK;
          count    = s.clicks;
          s.clicks = 4'd1;
        end
      end else begin
        s.wcnt = s.wcnt - 16'd1;
      end
    end

    if (!lvl_i && prev_i) begin
      if (!s.dbusy) begin
        s.dbusy = 1'b1;
        s.dcnt  = cfg_i.debounce;
      end
    end else if (lvl_i && !prev_i && s.pressed) begin
      s.pressed = 1'b0;
      if (s.dur > cfg_i.long_press) begin
        emit  = 1'b1;
        kind  = EVT_LONG;
        count = 4'd0;
      end else begin
        s.wbusy = 1'b1;
        s.wcnt  = cfg_i.window;
      end
    end

    upd_o.st    = s;
    upd_o.emit  = emit;
    upd_o.kind  = kind;
    upd_o.count = count;
  end

endmodule

[sv/kdlpmc_evt_queue.sv]
// Event queue: holds back one event per tick to mark the last, then buffers words out.
`timescale 1ns / 1ps
module kdlpmc_evt_queue import kdlpmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              evt_valid_i,
  input  evt_t              evt_i,
  input  logic              tick_end_i,
  output logic              out_valid_o,
  output evt_t              out_evt_o,
  input  logic              out_stall_i,
  output logic [QCNT_W-1:0] count_o
);

  evt_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              pend_v_q, pend_v_d;
  evt_t              pend_q, pend_d;
  logic              push0, push1, pop;
  evt_t              d0, d1;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    push0    = 1'b0;
    push1    = 1'b0;
    d0       = pend_q;
    d0.last  = 1'b0;
    d1       = evt_i;
    d1.last  = 1'b1;
    if (tick_end_i) begin
      pend_v_d = 1'b0;
    end
    if (evt_valid_i) begin
      if (pend_v_q) begin
        push0 = 1'b1;
        push1 = tick_end_i;
      end else if (tick_end_i) begin
        push0   = 1'b1;
        d0      = evt_i;
        d0.last = 1'b1;
      end
      // hold the newest word back until the next one or the end of the tick
      if (!tick_end_i) begin
        pend_v_d = 1'b1;
        pend_d   = evt_i;
      end
    end else if (tick_end_i && pend_v_q) begin
      push0   = 1'b1;
      d0.last = 1'b1;
    end
  end

  assign pop = (count_q != '0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      count_q  <= '0;
    end else begin
      pend_v_q <= pend_v_d;
      wptr_q   <= wptr_q + QPTR_W'(push0) + QPTR_W'(push1);
      rptr_q   <= rptr_q + QPTR_W'(pop);
      count_q  <= count_q + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (push0) begin
      mem_q[wptr_q] <= d0;
    end
    if (push1) begin
      mem_q[QPTR_W'(wptr_q + 1'b1)] <= d1;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_evt_o   = mem_q[rptr_q];
  assign count_o     = count_q;

endmodule

[sv/key_debounce_long_press_multi_click.sv]
// Top level: tick sequencer over the per-key state RAM, config registers, event output.
// Order: with no output stall the last word of a tick leaves once the tick's last key is updated;
// an earlier word leaves once the tick's next word reaches the queue.
// Throughput: the key state RAM serves one key a cycle; a new tick can start as the last key issues.
// Input stalls when the event queue lacks room for the events of the ticks in flight.
// Reset: all keys released, per-key state reads as idle with a click count of one
// (valid bit per entry), registers return to 10, 1000 and 300 ticks.
`timescale 1ns / 1ps
module key_debounce_long_press_multi_click import kdlpmc_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               key_valid_i,
  output logic               key_stall_o,
  input  logic [LEVEL_W-1:0] key_levels_i,
  output logic               evt_valid_o,
  input  logic               evt_stall_i,
  output logic [1:0]         key_index_o,
  output logic               event_kind_o,
  output logic [3:0]         click_count_o,
  output logic               last_event_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

  // configuration registers
  cfg_t cfg_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.long_press <= LONG_RST;
      cfg_q.window     <= WINDOW_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE: cfg_q.debounce   <= pwdata[7:0];
        REG_LONG:     cfg_q.long_press <= pwdata[15:0];
        REG_WINDOW:   cfg_q.window     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE: prdata = {24'd0, cfg_q.debounce};
      REG_LONG:     prdata = {16'd0, cfg_q.long_press};
      REG_WINDOW:   prdata = {16'd0, cfg_q.window};
      default:      prdata = 32'd0;
    endcase
  end

  // issue stage: walk the keys of the current tick
  logic               iss_busy_q;
  logic [KEY_W-1:0]   iss_key_q;
  logic [LEVEL_W-1:0] cur_levels_q, prev_levels_q;
  logic [1:0]         inflight_q;
  logic [QCNT_W-1:0]  q_count;
  logic               issue_free, room, key_accept;
  logic [4:0]         iss_key_ext;
  logic               iss_lvl, iss_prev;
  logic [QCNT_W+1:0]  reserved;

  assign issue_free  = !iss_busy_q || (iss_key_q == LAST_KEY);
  assign reserved    = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(MAX_RESULTS) * (QCNT_W+2)'(inflight_q);
  assign room        = reserved <= (QCNT_W+2)'(QUEUE_DEPTH - MAX_RESULTS);
  assign key_stall_o = !(issue_free && room);
  assign key_accept  = key_valid_i && !key_stall_o;

  // keys past the input word read as released
  assign iss_key_ext = 5'(iss_key_q);
  assign iss_lvl  = (iss_key_ext < 5'(LEVEL_W)) ? cur_levels_q[iss_key_ext[1:0]] : 1'b1;
  assign iss_prev = (iss_key_ext < 5'(LEVEL_W)) ? prev_levels_q[iss_key_ext[1:0]] : 1'b1;

  // update stage registers
  logic             s1_v_q, s1_last_q, s1_lvl_q, s1_prev_q;
  logic [KEY_W-1:0] s1_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_busy_q    <= 1'b0;
      iss_key_q     <= '0;
      cur_levels_q  <= '1;
      prev_levels_q <= '1;
      s1_v_q        <= 1'b0;
      s1_last_q     <= 1'b0;
      inflight_q    <= 2'd0;
    end else begin
      if (key_accept) begin
        prev_levels_q <= cur_levels_q;
        cur_levels_q  <= key_levels_i;
        iss_busy_q    <= 1'b1;
        iss_key_q     <= '0;
      end else if (iss_busy_q) begin
        if (iss_key_q == LAST_KEY) begin
          iss_busy_q <= 1'b0;
        end else begin
          iss_key_q <= KEY_W'(iss_key_q + 1'b1);
        end
      end
      s1_v_q     <= iss_busy_q;
      s1_last_q  <= iss_busy_q && (iss_key_q == LAST_KEY);
      inflight_q <= inflight_q + 2'(key_accept) - 2'(s1_v_q && s1_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_key_q  <= iss_key_q;
    s1_lvl_q  <= iss_lvl;
    s1_prev_q <= iss_prev;
  end

  // key state RAM with valid bits and same-entry forwarding
  logic [KEY_STATE_W-1:0] ram_rdata;
  logic [NUM_KEYS-1:0]    vld_q;
  logic                   byp_v_q;
  key_state_t             byp_q;
  key_state_t             st_cur;
  key_upd_t               upd;
  logic                   wr_en;

  assign wr_en = s1_v_q;

  kdlpmc_ram #(
    .WIDTH (KEY_STATE_W),
    .DEPTH (NUM_KEYS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_key_q),
    .wdata_i (upd.st),
    .raddr_i (iss_key_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (byp_v_q) begin
      st_cur = byp_q;
    end else if (vld_q[s1_key_q]) begin
      st_cur = key_state_t'(ram_rdata);
    end else begin
      st_cur = KEY_STATE_RST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      byp_v_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[s1_key_q] <= 1'b1;
      end
      // the read issued this cycle misses the write to the same entry
      byp_v_q <= wr_en && (s1_key_q == iss_key_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= upd.st;
  end

  kdlpmc_key_logic u_key_logic (
    .st_i   (st_cur),
    .lvl_i  (s1_lvl_q),
    .prev_i (s1_prev_q),
    .cfg_i  (cfg_q),
    .upd_o  (upd)
  );

  // events
  evt_t       evt_new, evt_out;
  logic [4:0] s1_key_ext;

  assign s1_key_ext    = 5'(s1_key_q);
  assign evt_new.key   = s1_key_ext[1:0];
  assign evt_new.kind  = upd.kind;
  assign evt_new.count = upd.count;
  assign evt_new.last  = 1'b0;

  kdlpmc_evt_queue u_evt_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (s1_v_q && upd.emit),
    .evt_i       (evt_new),
    .tick_end_i  (s1_v_q && s1_last_q),
    .out_valid_o (evt_valid_o),
    .out_evt_o   (evt_out),
    .out_stall_i (evt_stall_i),
    .count_o     (q_count)
  );

  assign key_index_o   = evt_out.key;
  assign event_kind_o  = evt_out.kind;
  assign click_count_o = evt_out.count;
  assign last_event_o  = evt_out.last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("event queue overflow");

  a_tick_end_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_last_q) |-> (inflight_q != 2'd0))
    else $error("tick finished with none in flight");

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_accept |=> (iss_busy_q && iss_key_q == '0))
    else $error("accepted word did not start at key zero");

endmodule

[bench/key_debounce_long_press_multi_click_tb.sv]
// Self-checking bench for the four-key debounce, long-press and multi-click detector.
`timescale 1ns / 1ps
module key_debounce_long_press_multi_click_tb;
  import kdlpmc_pkg::*;

  localparam int KEYS = NUM_KEYS_DEF;
  localparam int HOLD_CAP = 280;

  // Per-key tracking state of the predictor
  typedef struct {
    bit          dbusy;
    logic [7:0]  dcnt;
    bit          held;
    logic [15:0] dur;
    bit          wbusy;
    logic [15:0] wcnt;
    logic [3:0]  clicks;
  } key_track_t;

  class key_event_board;
    logic [7:0]  deb_len;
    logic [15:0] long_len;
    logic [15:0] win_len;
    logic [3:0]  prev_lv;
    key_track_t  trk[KEYS];
    evt_t        event_q[$];
    int          errors;
    int          n_events;
    int          n_long;
    int          n_click;
    int          n_full;
    int          max_clicks;

    function new();
      deb_len = DEBOUNCE_RST;
      long_len = LONG_RST;
      win_len = WINDOW_RST;
      prev_lv = '1;
      foreach (trk[k]) begin
        trk[k] = '{dbusy: 0, dcnt: 0, held: 0, dur: 0, wbusy: 0, wcnt: 0, clicks: 4'd1};
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_DEBOUNCE: deb_len = val[7:0];
        REG_LONG:     long_len = val[15:0];
        REG_WINDOW:   win_len = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return event_q.size();
    endfunction

    // Advance every key by one tick and queue the events it raises
    function void note_tick(logic [3:0] lv);
      int   first;
      bit   lvl, prv, emit;
      logic kind;
      logic [3:0] cnt;
      evt_t ev;
      first = event_q.size();
      for (int k = 0; k < KEYS; k++) begin
        lvl = (k < LEVEL_W) ? lv[k] : 1'b1;
        prv = (k < LEVEL_W) ? prev_lv[k] : 1'b1;
        emit = 0;
        kind = EVT_LONG;
        cnt = 4'd0;
        if (trk[k].held && trk[k].dur != DUR_MAX) trk[k].dur++;
        if (trk[k].dbusy) begin
          if (trk[k].dcnt <= 8'd1) begin
            trk[k].dbusy = 0;
            trk[k].dcnt = 8'd0;
            if (!lvl) begin
              trk[k].held = 1;
              trk[k].dur = 16'd0;
            end
          end else begin
            trk[k].dcnt--;
          end
        end
        if (trk[k].wbusy) begin
          if (trk[k].wcnt <= 16'd1) begin
            trk[k].wbusy = 0;
            trk[k].wcnt = 16'd0;
            if (trk[k].held) begin
              if (trk[k].clicks != CLICK_MAX) trk[k].clicks++;
            end else begin
              emit = 1;
              kind = EVT_CLICK;
              cnt = trk[k].clicks;
              trk[k].clicks = 4'd1;
            end
          end else begin
            trk[k].wcnt--;
          end
        end
        if (!lvl && prv) begin
          if (!trk[k].dbusy) begin
            trk[k].dbusy = 1;
            trk[k].dcnt = deb_len;
          end
        end else if (lvl && !prv && trk[k].held) begin
          trk[k].held = 0;
          if (trk[k].dur > long_len) begin
            emit = 1;
            kind = EVT_LONG;
            cnt = 4'd0;
          end else begin
            trk[k].wbusy = 1;
            trk[k].wcnt = win_len;
          end
        end
        if (emit) begin
          ev.key = 2'(k);
          ev.kind = kind;
          ev.count = cnt;
          ev.last = 1'b0;
          event_q.push_back(ev);
          n_events++;
          if (kind == EVT_LONG) n_long++;
          else n_click++;
          if (int'(cnt) > max_clicks) max_clicks = int'(cnt);
        end
      end
      // mark the final event of this tick
      if (event_q.size() > first) begin
        ev = event_q.pop_back();
        ev.last = 1'b1;
        event_q.push_back(ev);
      end
      if (event_q.size() - first == KEYS) n_full++;
      prev_lv = lv;
    endfunction

    function void check_event(logic [1:0] key, logic kind, logic [3:0] cnt, logic last);
      evt_t ev;
      if (event_q.size() == 0) begin
        errors++;
        $display("%0t: event with none expected: key %0d kind %0d count %0d last %0d",
                 $time, key, kind, cnt, last);
        return;
      end
      ev = event_q.pop_front();
      if (ev.key !== key || ev.kind !== kind || ev.count !== cnt || ev.last !== last) begin
        errors++;
        // fields in order key/kind/count/last
        $display("%0t: event mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                 $time, ev.key, ev.kind, ev.count, ev.last, key, kind, cnt, last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               key_valid_i = 1'b0;
  logic               key_stall_o;
  logic [LEVEL_W-1:0] key_levels_i = '1;
  logic               evt_valid_o;
  logic               evt_stall_i = 1'b0;
  logic [1:0]         key_index_o;
  logic               event_kind_o;
  logic [3:0]         click_count_o;
  logic               last_event_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  key_debounce_long_press_multi_click DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_valid_i   (key_valid_i),
    .key_stall_o   (key_stall_o),
    .key_levels_i  (key_levels_i),
    .evt_valid_o   (evt_valid_o),
    .evt_stall_i   (evt_stall_i),
    .key_index_o   (key_index_o),
    .event_kind_o  (event_kind_o),
    .click_count_o (click_count_o),
    .last_event_o  (last_event_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  key_event_board sb = new();
  int  reg_errors = 0;
  int  n_ticks = 0;
  int  n_settings = 0;
  bit  tx_calm = 0;
  bit  rx_calm = 0;
  int  stall_left = 0;
  int  rx_gap;
  bit  lvl_q[KEYS][$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic int clip(int n);
    return (n > HOLD_CAP) ? HOLD_CAP : n;
  endfunction

  // Event sink: check each accepted word, then hold stall for a drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (evt_valid_o && !evt_stall_i) begin
        sb.check_event(key_index_o, event_kind_o, click_count_o, last_event_o);
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        rx_gap = draw_wait(rx_calm);
        stall_left <= rx_gap;
        evt_stall_i <= (rx_gap != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
        stall_left <= 0;
        evt_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_tick(logic [3:0] lv);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      key_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_valid_i <= 1'b1;
    key_levels_i <= lv;
    do @(posedge clk_i); while (key_stall_o);
    sb.note_tick(lv);
    n_ticks++;
  endtask

  task automatic end_stream();
    key_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_check(logic [1:0] idx, logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      reg_errors++;
      $display("%0t: register %0d readback: expected %0d, got %0d", $time, idx, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_register(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    read_check(idx, val);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * KEYS + 8) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [7:0] deb, logic [15:0] lng, logic [15:0] win);
    wait_drained();
    set_register(REG_DEBOUNCE, {24'd0, deb});
    set_register(REG_LONG, {16'd0, lng});
    set_register(REG_WINDOW, {16'd0, win});
    n_settings++;
  endtask

  task automatic add_run(int k, bit lvl, int n);
    repeat (n) lvl_q[k].push_back(lvl);
  endtask

  // Queue one gesture for key k: a click burst, a long press, or a little noise
  task automatic plan_gesture(int k);
    int d_eff, w_eff, pick, clicks, low, gap;
    d_eff = (sb.deb_len == 0) ? 1 : int'(sb.deb_len);
    w_eff = (sb.win_len == 0) ? 1 : int'(sb.win_len);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      clicks = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
      gap = 0;
      for (int n = 0; n < clicks; n++) begin
        low = d_eff + 1 + $urandom_range(0, 1);
        // stay low until the window closes so the click extends the burst
        if (n > 0 && w_eff - gap + 1 > low) low = w_eff - gap + 1;
        add_run(k, 1'b0, clip(low));
        if (n == clicks - 1) gap = w_eff + $urandom_range(1, 3);
        else gap = (w_eff > d_eff) ? $urandom_range(1, w_eff - d_eff) : 1;
        add_run(k, 1'b1, clip(gap));
      end
    end else if (pick < 8) begin
      add_run(k, 1'b0, clip(d_eff + int'(sb.long_len) + 1 + $urandom_range(0, 2)));
      add_run(k, 1'b1, clip($urandom_range(1, w_eff + 2)));
    end else begin
      repeat ($urandom_range(1, 4)) lvl_q[k].push_back(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int min_ticks, int want_events, int max_ticks);
    int t, ev0;
    logic [3:0] lv;
    ev0 = sb.n_events;
    t = 0;
    for (int k = 0; k < KEYS; k++) lvl_q[k].delete();
    while (t < min_ticks || (sb.n_events - ev0 < want_events && t < max_ticks)) begin
      for (int k = 0; k < KEYS; k++) begin
        if (lvl_q[k].size() == 0) plan_gesture(k);
        lv[k] = lvl_q[k].pop_front();
      end
      send_tick(lv);
      t++;
    end
    end_stream();
  endtask

  initial begin
    logic [3:0] seq[$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_check(REG_DEBOUNCE, {24'd0, DEBOUNCE_RST});
    read_check(REG_LONG, {16'd0, LONG_RST});
    read_check(REG_WINDOW, {16'd0, WINDOW_RST});

    // Directed: long press on all keys, short press on all keys, a glitch on key 0,
    // and a double click on key 1
    apply_setting(8'd1, 16'd6, 16'd3);
    seq = '{4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF,
            4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF,
            4'hC, 4'hD, 4'hF, 4'hD, 4'hD, 4'hF, 4'hF, 4'hF, 4'hF};
    foreach (seq[i]) send_tick(seq[i]);
    end_stream();

    apply_setting(8'd2, 16'd10, 16'd4);
    run_phase(20, 6, 24);
    apply_setting(8'd0, 16'd0, 16'd0);
    run_phase(16, 4, 20);
    apply_setting(8'd3, 16'd8, 16'd6);
    run_phase(16, 4, 20);
    apply_setting(8'd1, 16'd65535, 16'd65535);
    run_phase(8, 0, 8);
    apply_setting(8'd255, 16'd0, 16'd1);
    run_phase(8, 0, 8);
    apply_setting(8'd1, 16'd65535, 16'd2);
    run_phase(36, 4, 40);
    apply_setting(8'd1, 16'd3, 16'd5);
    run_phase(16, 4, 20);

    wait_drained();
    $display("Covered %0d ticks under %0d register settings: %0d long presses, %0d bursts",
             n_ticks, n_settings, sb.n_long, sb.n_click);
    $display("Largest burst count %0d; %0d ticks raised an event on every key",
             sb.max_clicks, sb.n_full);
    if (sb.errors == 0 && reg_errors == 0) begin
      $display("** key_debounce_long_press_multi_click: PASSED **");
    end else begin
      $display("** key_debounce_long_press_multi_click: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d events still expected", sb.pending());
    $display("** key_debounce_long_press_multi_click: FAILED **");
    $finish;
  end

endmodule
